// ----- rtl/sta_lta_transient_detector_assert.svh -----
// Assertion macros shared by the detector's checker
`ifndef STA_LTA_TRANSIENT_DETECTOR_ASSERT_SVH
`define STA_LTA_TRANSIENT_DETECTOR_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted
`define SLTD_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("sta_lta_transient_detector: check failed");

// Next-cycle implication, disabled while reset is asserted
`define SLTD_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("sta_lta_transient_detector: check failed");

`endif

// ----- rtl/sltd_pkg.sv -----
// Shared constants and types for the STA/LTA transient detector
`default_nettype none

package sltd_pkg;

  // Configuration register widths and reset values
  localparam int THR_W      = 12;
  localparam int COOL_W     = 20;
  localparam int CFG_DATA_W = 20;
  localparam int CFG_IDX_W  = 1;
  localparam int THR_RESET  = 274;

  typedef logic [CFG_IDX_W-1:0] cfg_idx_t;

  // Register indexes on the configuration port
  localparam cfg_idx_t REG_THRESHOLD = 1'b0;
  localparam cfg_idx_t REG_COOLDOWN  = 1'b1;

endpackage

`default_nettype wire

// ----- rtl/sta_lta_transient_detector.sv -----
// Top level of the STA/LTA transient detector
//
//   channel  | handshake                | payload
//   ---------+--------------------------+---------------------------------
//   input    | in_valid_i / in_ready_o  | sample_i
//   result   | out_valid_o / out_ready_i| clap_o, armed_o
//   config   | cfg_we_i (no wait)       | cfg_idx_i, cfg_data_i
//
// One request per cycle sustained while results are taken; a request passes the
// input stage (with ring read), then the result register (after sum update and
// ratio test). The pace is set by the running-sum and ratio-test loop. Reset
// clears pointers, sums, counters and valids; no clearing pass. A stalled result
// holds the input stage, and the input stage still takes one request while the
// result register is full.
`default_nettype none

module sta_lta_transient_detector import sltd_pkg::*; #(
  parameter int SHORT_WINDOW = 20,
  parameter int LONG_WINDOW  = 400,
  parameter int SAMPLE_BITS  = 12
) (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire logic                   in_valid_i,
  output logic                        in_ready_o,
  input  wire logic [SAMPLE_BITS-1:0] sample_i,
  output logic                        out_valid_o,
  input  wire logic                   out_ready_i,
  output logic                        clap_o,
  output logic                        armed_o,
  input  wire logic                   cfg_we_i,
  input  wire cfg_idx_t               cfg_idx_i,
  input  wire logic [CFG_DATA_W-1:0]  cfg_data_i
);

  localparam int SW_BITS = $clog2(SHORT_WINDOW + 1);
  localparam int LW_BITS = $clog2(LONG_WINDOW + 1);
  localparam int SUM_S_W = SAMPLE_BITS + SW_BITS;
  localparam int SUM_L_W = SAMPLE_BITS + LW_BITS;
  localparam int SP_W    = (SHORT_WINDOW > 1) ? $clog2(SHORT_WINDOW) : 1;
  localparam int LP_W    = $clog2(LONG_WINDOW);
  localparam int FILL_W  = LW_BITS;
  localparam int SCL_W   = THR_W + SW_BITS;

  localparam logic [SP_W-1:0]   SP_LAST   = SP_W'(SHORT_WINDOW - 1);
  localparam logic [LP_W-1:0]   LP_LAST   = LP_W'(LONG_WINDOW - 1);
  localparam logic [FILL_W-1:0] FILL_FULL = FILL_W'(LONG_WINDOW);
  localparam logic [SCL_W-1:0]  SCL_RESET = SCL_W'(THR_RESET * SHORT_WINDOW);

  // Configuration
  logic [SCL_W-1:0]  thr_scl_q;
  logic [COOL_W-1:0] cool_cfg_q;

  // Input stage and result register
  logic                   s1_valid_q;
  logic [SAMPLE_BITS-1:0] s1_sample_q;
  logic                   out_valid_q;
  logic                   clap_q;
  logic                   armed_q;

  // Window state
  logic [SP_W-1:0]    sp_q;
  logic [LP_W-1:0]    lp_q;
  logic [SUM_S_W-1:0] sum_s_q;
  logic [SUM_L_W-1:0] sum_l_q;
  logic [FILL_W-1:0]  fill_q;
  logic [COOL_W-1:0]  cool_q;

  logic                   in_fire;
  logic                   s1_adv;
  logic                   filling;
  logic                   cooling;
  logic                   push;
  logic                   drop_s;
  logic                   drop_l;
  logic                   armed;
  logic                   hit;
  logic [SP_W-1:0]        sp_inc;
  logic [LP_W-1:0]        lp_inc;
  logic [SP_W-1:0]        sp_rd;
  logic [LP_W-1:0]        lp_rd;
  logic [SAMPLE_BITS-1:0] old_s;
  logic [SAMPLE_BITS-1:0] old_l;
  logic [SUM_S_W-1:0]     sum_s_d;
  logic [SUM_L_W-1:0]     sum_l_d;

  // Handshake: the input stage moves on whenever the result register is free
  assign s1_adv     = s1_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o = !s1_valid_q || s1_adv;
  assign in_fire    = in_valid_i && in_ready_o;

  // Mode of the request in the input stage
  assign filling = fill_q < FILL_FULL;
  assign cooling = !filling && (cool_q != '0);
  assign push    = !cooling;
  assign drop_l  = !filling;
  assign drop_s  = !filling || (int'(fill_q) >= SHORT_WINDOW);
  assign armed   = !filling && !cooling;

  // Pointer increments with wrap
  assign sp_inc = (sp_q == SP_LAST) ? '0 : sp_q + SP_W'(1);
  assign lp_inc = (lp_q == LP_LAST) ? '0 : lp_q + LP_W'(1);

  // Read ahead for the request being accepted: slot after the current push
  assign sp_rd = (s1_adv && push) ? sp_inc : sp_q;
  assign lp_rd = (s1_adv && push) ? lp_inc : lp_q;

  sltd_ring #(
    .DEPTH (SHORT_WINDOW),
    .WIDTH (SAMPLE_BITS)
  ) u_short_ring (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .we_i    (s1_adv && push),
    .waddr_i (sp_q),
    .wdata_i (s1_sample_q),
    .re_i    (in_fire),
    .raddr_i (sp_rd),
    .rdata_o (old_s)
  );

  sltd_ring #(
    .DEPTH (LONG_WINDOW),
    .WIDTH (SAMPLE_BITS)
  ) u_long_ring (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .we_i    (s1_adv && push),
    .waddr_i (lp_q),
    .wdata_i (s1_sample_q),
    .re_i    (in_fire),
    .raddr_i (lp_rd),
    .rdata_o (old_l)
  );

  // Running sums: restart at the start of a fill, drop the oldest when full
  always_comb begin
    sum_s_d = (fill_q == '0) ? '0 : sum_s_q;
    sum_l_d = (fill_q == '0) ? '0 : sum_l_q;
    if (drop_s) begin
      sum_s_d = sum_s_d - SUM_S_W'(old_s);
    end
    if (drop_l) begin
      sum_l_d = sum_l_d - SUM_L_W'(old_l);
    end
    sum_s_d = sum_s_d + SUM_S_W'(s1_sample_q);
    sum_l_d = sum_l_d + SUM_L_W'(s1_sample_q);
  end

  sltd_cmp #(
    .LONG_WINDOW (LONG_WINDOW),
    .SUM_S_W     (SUM_S_W),
    .SUM_L_W     (SUM_L_W),
    .SCL_W       (SCL_W)
  ) u_cmp (
    .short_sum_i (sum_s_d),
    .long_sum_i  (sum_l_d),
    .thr_scl_i   (thr_scl_q),
    .hit_o       (hit)
  );

  // Configuration writes; the threshold is kept pre-scaled by the short window
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_scl_q  <= SCL_RESET;
      cool_cfg_q <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_THRESHOLD: thr_scl_q  <= SCL_W'(cfg_data_i[THR_W-1:0]) * SCL_W'(SHORT_WINDOW);
        REG_COOLDOWN:  cool_cfg_q <= cfg_data_i[COOL_W-1:0];
        default:       ;
      endcase
    end
  end

  // Input stage
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      s1_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      s1_sample_q <= sample_i;
    end
  end

  // Window state update
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sp_q    <= '0;
      lp_q    <= '0;
      sum_s_q <= '0;
      sum_l_q <= '0;
      fill_q  <= '0;
      cool_q  <= '0;
    end else if (s1_adv) begin
      if (push) begin
        sp_q    <= sp_inc;
        lp_q    <= lp_inc;
        sum_s_q <= sum_s_d;
        sum_l_q <= sum_l_d;
      end
      if (filling) begin
        fill_q <= fill_q + FILL_W'(1);
      end else if (cooling) begin
        cool_q <= cool_q - COOL_W'(1);
      end else if (hit) begin
        fill_q <= '0;
        cool_q <= cool_cfg_q;
      end
    end
  end

  // Result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (s1_adv) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_adv) begin
      clap_q  <= armed && hit;
      armed_q <= armed;
    end
  end

  assign out_valid_o = out_valid_q;
  assign clap_o      = clap_q;
  assign armed_o     = armed_q;

endmodule

`default_nettype wire

// ----- rtl/sltd_ring.sv -----
// Sample ring store: one write port, one registered read port with write bypass
`default_nettype none

module sltd_ring #(
  parameter int DEPTH = 400,
  parameter int WIDTH = 12,
  localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              we_i,
  input  wire logic [ADDR_W-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]  wdata_i,
  input  wire logic              re_i,
  input  wire logic [ADDR_W-1:0] raddr_i,
  output logic      [WIDTH-1:0]  rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_q;
  logic [WIDTH-1:0] byp_data_q;
  logic             byp_q;

  // Storage array, read data held until the next read
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rd_q       <= mem[raddr_i];
      byp_data_q <= wdata_i;
    end
  end

  // Read of the entry being written in the same cycle takes the new data
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      byp_q <= 1'b0;
    end else if (re_i) begin
      byp_q <= we_i && (waddr_i == raddr_i);
    end
  end

  assign rdata_o = byp_q ? byp_data_q : rd_q;

endmodule

`default_nettype wire

// ----- rtl/sltd_cmp.sv -----
// Cross-multiplied ratio test: short_sum * LONG * 256 > threshold * SHORT * long_sum
`default_nettype none

module sltd_cmp import sltd_pkg::*; #(
  parameter int LONG_WINDOW = 400,
  parameter int SUM_S_W     = 17,
  parameter int SUM_L_W     = 21,
  parameter int SCL_W       = 17
) (
  input  wire logic [SUM_S_W-1:0] short_sum_i,
  input  wire logic [SUM_L_W-1:0] long_sum_i,
  input  wire logic [SCL_W-1:0]   thr_scl_i,
  output logic                    hit_o
);

  localparam int LHS_W = SUM_S_W + $clog2(LONG_WINDOW + 1) + 8;
  localparam int RHS_W = SCL_W + SUM_L_W;
  localparam int CMP_W = (LHS_W > RHS_W) ? LHS_W : RHS_W;
  localparam logic [CMP_W-1:0] LHS_SCALE = CMP_W'(LONG_WINDOW * 256);

  logic [CMP_W-1:0] lhs;
  logic [CMP_W-1:0] rhs;

  // Constant scale on the short side, one real product on the long side
  always_comb begin
    lhs   = CMP_W'(short_sum_i) * LHS_SCALE;
    rhs   = CMP_W'(RHS_W'(thr_scl_i) * RHS_W'(long_sum_i));
    hit_o = lhs > rhs;
  end

endmodule

`default_nettype wire

// ----- rtl/sltd_check.sv -----
// Port-level checker for the detector, bound to the top level
`default_nettype none

`include "sta_lta_transient_detector_assert.svh"

module sltd_check (
  input wire logic clk_i,
  input wire logic rst_ni,
  input wire logic in_ready_o,
  input wire logic out_valid_o,
  input wire logic out_ready_i,
  input wire logic clap_o,
  input wire logic armed_o
);

  // A transient is only flagged on a tested sample
  `SLTD_ASSERT_IMPL(a_clap_armed, clk_i, rst_ni, out_valid_o && clap_o, armed_o)

  // Input side only stalls behind a waiting result
  `SLTD_ASSERT_IMPL(a_stall_cause, clk_i, rst_ni, !in_ready_o, out_valid_o)

  // The sample after a detection starts a refill, so it is never armed
  `SLTD_ASSERT_NEXT(a_refill, clk_i, rst_ni, out_valid_o && out_ready_i && clap_o, !(out_valid_o && armed_o))

  // A refused result is held
  `SLTD_ASSERT_NEXT(a_hold, clk_i, rst_ni, out_valid_o && !out_ready_i, out_valid_o && $stable(clap_o) && $stable(armed_o))

endmodule

bind sta_lta_transient_detector sltd_check u_sltd_check (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_ready_o  (in_ready_o),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .clap_o      (clap_o),
  .armed_o     (armed_o)
);

`default_nettype wire

// ----- tb/sv/tb_detector_pkg.sv -----
// Window model and result scoreboard for the transient detector testbench
`timescale 1ns / 100ps

package clap_check_pkg;
  import sltd_pkg::*;

  localparam int SHORT_LEN = 20;
  localparam int LONG_LEN  = 400;
  localparam int SAMPLE_W  = 12;

  typedef logic [SAMPLE_W-1:0] sample_t;

  typedef struct packed {
    logic clap;
    logic armed;
  } flags_t;

  class clap_scoreboard;
    sample_t           long_ring [LONG_LEN];
    sample_t           short_ring [SHORT_LEN];
    logic [16:0]       short_sum;
    logic [20:0]       long_sum;
    int unsigned       long_pos;
    int unsigned       short_pos;
    int unsigned       fill_count;
    logic [COOL_W-1:0] cool_left;
    logic [THR_W-1:0]  threshold;
    logic [COOL_W-1:0] cool_reload;
    flags_t            flag_queue [$];
    int                errors;

    function new();
      short_sum   = '0;
      long_sum    = '0;
      long_pos    = 0;
      short_pos   = 0;
      fill_count  = 0;
      cool_left   = '0;
      threshold   = THR_W'(THR_RESET);
      cool_reload = '0;
      errors      = 0;
    endfunction

    function void set_reg(cfg_idx_t idx, logic [CFG_DATA_W-1:0] value);
      if (idx == REG_THRESHOLD) begin
        threshold = value[THR_W-1:0];
      end else if (idx == REG_COOLDOWN) begin
        cool_reload = value[COOL_W-1:0];
      end
    endfunction

    // Push one sample into both rings, retiring the oldest entries as asked
    function void window_push(sample_t s, bit drop_long, bit drop_short);
      if (drop_long) long_sum = long_sum - long_ring[long_pos];
      if (drop_short) short_sum = short_sum - short_ring[short_pos];
      long_ring[long_pos]   = s;
      short_ring[short_pos] = s;
      long_sum  = long_sum + s;
      short_sum = short_sum + s;
      long_pos  = (long_pos + 1) % LONG_LEN;
      short_pos = (short_pos + 1) % SHORT_LEN;
    endfunction

    // Accepted request: advance the model and queue the flags it should give
    function void note_sample(sample_t s);
      flags_t      want;
      logic [63:0] lhs;
      logic [63:0] rhs;
      want = '0;
      if (fill_count < LONG_LEN) begin
        // a fresh fill restarts both sums
        if (fill_count == 0) begin
          short_sum = '0;
          long_sum  = '0;
        end
        window_push(s, 1'b0, fill_count >= SHORT_LEN);
        fill_count++;
      end else if (cool_left != 0) begin
        cool_left--;
      end else begin
        window_push(s, 1'b1, 1'b1);
        want.armed = 1'b1;
        // ratio test by cross-multiplication, strict
        lhs = 64'(short_sum) * 64'(LONG_LEN) * 64'd256;
        rhs = 64'(threshold) * 64'(long_sum) * 64'(SHORT_LEN);
        if (lhs > rhs) begin
          want.clap  = 1'b1;
          fill_count = 0;
          cool_left  = cool_reload;
        end
      end
      flag_queue.push_back(want);
    endfunction

    function void check_result(logic clap, logic armed);
      flags_t want;
      if (flag_queue.size() == 0) begin
        $display("%0t ns: result with none expected: expected none, actual clap=%0b armed=%0b",
                 $time, clap, armed);
        errors++;
      end else begin
        want = flag_queue.pop_front();
        if (clap !== want.clap) begin
          $display("%0t ns: clap mismatch: expected %0b, actual %0b", $time, want.clap, clap);
          errors++;
        end
        if (armed !== want.armed) begin
          $display("%0t ns: armed mismatch: expected %0b, actual %0b", $time, want.armed,
                   armed);
          errors++;
        end
      end
    endfunction

    function int pending();
      return flag_queue.size();
    endfunction
  endclass

endpackage

// ----- tb/sv/tb_top.sv -----
// Top-level testbench: drives the transient detector and checks every result
`timescale 1ns / 100ps

module tb_top;
  import sltd_pkg::*;
  import clap_check_pkg::*;

  typedef enum int {PAT_NOISE, PAT_CLAPS, PAT_STEADY} pattern_e;

  logic                  clk_i     = 1'b0;
  logic                  rst_ni    = 1'b0;
  logic                  in_valid  = 1'b0;
  logic                  in_ready;
  sample_t               sample_in = '0;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  logic                  clap;
  logic                  armed;
  logic                  cfg_we    = 1'b0;
  cfg_idx_t              cfg_idx   = REG_THRESHOLD;
  logic [CFG_DATA_W-1:0] cfg_data  = '0;

  bit             idle_on    = 1'b0;
  int             stall_left = 0;
  int             base_level = 0;
  int             burst_left = 0;
  int             burst_amp  = 0;
  clap_scoreboard sb;

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  sta_lta_transient_detector dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .sample_i    (sample_in),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .clap_o      (clap),
    .armed_o     (armed),
    .cfg_we_i    (cfg_we),
    .cfg_idx_i   (cfg_idx),
    .cfg_data_i  (cfg_data)
  );

  // Receiver back-pressure in random bursts, only while idle_on is set
  always @(posedge clk_i) begin
    if (stall_left > 0) begin
      stall_left = stall_left - 1;
      out_ready <= 1'b0;
    end else if (idle_on && $urandom_range(0, 7) == 0) begin
      stall_left = $urandom_range(0, 4);
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
    end
  end

  // Result monitor
  always @(posedge clk_i) begin
    if (rst_ni && out_valid && out_ready) sb.check_result(clap, armed);
  end

  // One request; valid stays up after acceptance until the next call decides
  task automatic send_sample(input sample_t s);
    int gap;
    if (idle_on && $urandom_range(0, 5) == 0) begin
      gap = $urandom_range(1, 5);
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid  <= 1'b1;
    sample_in <= s;
    do @(posedge clk_i); while (!in_ready);
    sb.note_sample(s);
  endtask

  // Hold off the sender until every queued result has come back
  task automatic drain_results();
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_configuration(input logic [THR_W-1:0] thr,
                                     input logic [COOL_W-1:0] cool);
    cfg_we   <= 1'b1;
    cfg_idx  <= REG_THRESHOLD;
    cfg_data <= CFG_DATA_W'(thr);
    @(posedge clk_i);
    cfg_idx  <= REG_COOLDOWN;
    cfg_data <= CFG_DATA_W'(cool);
    @(posedge clk_i);
    cfg_we <= 1'b0;
    sb.set_reg(REG_THRESHOLD, CFG_DATA_W'(thr));
    sb.set_reg(REG_COOLDOWN, CFG_DATA_W'(cool));
  endtask

  // Sample source: uniform noise, quiet floor with loud bursts, or a near-flat level
  function automatic sample_t pick_sample(pattern_e pat);
    int v;
    case (pat)
      PAT_NOISE: begin
        v = $urandom_range(0, 4095);
      end
      PAT_CLAPS: begin
        if (burst_left == 0 && $urandom_range(0, 59) == 0) begin
          burst_left = $urandom_range(5, 30);
          burst_amp  = $urandom_range(300, 4095);
        end
        if (burst_left > 0) begin
          burst_left--;
          v = $urandom_range(burst_amp / 2, burst_amp);
        end else begin
          v = base_level + $urandom_range(0, 63);
        end
      end
      default: begin
        v = base_level + $urandom_range(0, 3);
      end
    endcase
    if (v > 4095) v = 4095;
    return sample_t'(v);
  endfunction

  initial begin
    int                random_items;
    int                phase_len;
    int                waited;
    pattern_e          pat;
    logic [THR_W-1:0]  thr;
    logic [COOL_W-1:0] cool;
    sb = new();
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    idle_on = 1'b1;

    // Equal ratio at unity threshold: a flat full-scale signal never flags
    write_configuration(12'd256, '0);
    repeat (LONG_LEN + 3) send_sample(12'hFFF);
    send_sample('0);

    // Zero threshold: any non-zero short sum flags
    drain_results();
    write_configuration('0, '0);
    send_sample(12'hFFF);

    // Refill with silence: armed with both sums zero gives no flag, one LSB flags
    repeat (LONG_LEN + 1) send_sample('0);
    send_sample(12'd1);

    // Top threshold: a loud sample after silence still flags; short cooldown
    drain_results();
    write_configuration(12'hFFF, 20'd3);
    repeat (LONG_LEN) send_sample('0);
    send_sample(12'hFFF);

    // Random phases, each with its own settings and signal shape
    random_items = 0;
    while (random_items < 400) begin
      drain_results();
      case ($urandom_range(0, 4))
        0:       thr = THR_W'($urandom_range(0, 4095));
        1, 2:    thr = THR_W'($urandom_range(256, 330));
        default: thr = THR_W'(THR_RESET);
      endcase
      cool = COOL_W'(($urandom_range(0, 4) == 0) ? $urandom_range(100, 300) :
                                                   $urandom_range(0, 30));
      case ($urandom_range(0, 4))
        0:       pat = PAT_NOISE;
        4:       pat = PAT_STEADY;
        default: pat = PAT_CLAPS;
      endcase
      base_level = (pat == PAT_STEADY) ? $urandom_range(0, 4092) : $urandom_range(0, 800);
      burst_left = 0;
      idle_on    = ($urandom_range(0, 3) != 0);
      phase_len  = $urandom_range(150, 350);
      // last stretch runs flat out on both sides
      if (random_items + phase_len >= 400) idle_on = 1'b0;
      write_configuration(thr, cool);
      repeat (phase_len) send_sample(pick_sample(pat));
      random_items += phase_len;
    end

    in_valid <= 1'b0;
    waited = 0;
    while (sb.pending() != 0 && waited < 5000) begin
      @(posedge clk_i);
      waited++;
    end
    repeat (8) @(posedge clk_i);
    if (sb.pending() != 0) begin
      $display("%0t ns: results missing: expected %0d more, actual 0", $time, sb.pending());
      sb.errors++;
    end
    if (sb.errors == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #5_000_000;
    $display("Simulation FAILED");
    $finish;
  end

endmodule
